// ===== hw/rtl/kclp_pkg.sv =====
// shared types and constants for the key click / long press detector
// no dependencies; used by every module of the block

package kclp_pkg;

  // key set size and field widths
  localparam int NUM_KEYS = 8;
  localparam int KEY_W    = 3;
  localparam int TICK_W   = 16;
  localparam int PRESS_W  = 8;
  localparam int EV_W     = 3;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 4;

  localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};
  localparam logic [PRESS_W-1:0] PRESS_MAX = {PRESS_W{1'b1}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE  = 4'd0,
    CFG_LONG      = 4'd1,
    CFG_HOLD      = 4'd2,
    CFG_REPEAT    = 4'd3
  } cfg_reg_e;

  // per-key mode, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_DOWN = 4'b0010,
    MODE_LONG = 4'b0100,
    MODE_UP   = 4'b1000
  } mode_e;

  // event codes
  typedef enum logic [EV_W-1:0] {
    EV_DOWN         = 3'd0,
    EV_UP           = 3'd1,
    EV_LONG_START   = 3'd2,
    EV_LONG_HOLD    = 3'd3,
    EV_LONG_RELEASE = 3'd4,
    EV_REPEAT       = 3'd5
  } event_e;

  typedef struct packed {
    logic [KEY_W-1:0] key_index;
    logic             raw_level;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_number;
    logic [EV_W-1:0]  event_code;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] hold_period_ticks;
    logic [CFG_W-1:0] repeat_window_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic               settled;
    mode_e              mode;
    logic [TICK_W-1:0]  ticks;
    logic [PRESS_W-1:0] presses;
  } key_state_t;

  typedef struct packed {
    logic   fire;
    event_e ev;
  } step_res_t;

endpackage

// ===== hw/rtl/kclp_cfg.sv =====
// configuration registers of the key click / long press detector
// depends on kclp_pkg

module kclp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [kclp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kclp_pkg::CFG_W-1:0]     cfg_wdata,
  output kclp_pkg::cfg_regs_t            regs
);

  kclp_pkg::cfg_regs_t regs_r;
  kclp_pkg::cfg_regs_t regs_nxt;

  // decode the write; unknown indexes are dropped
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_index)
        kclp_pkg::CFG_DEBOUNCE: regs_nxt.debounce_ticks      = cfg_wdata;
        kclp_pkg::CFG_LONG:     regs_nxt.long_press_ticks    = cfg_wdata;
        kclp_pkg::CFG_HOLD:     regs_nxt.hold_period_ticks   = cfg_wdata;
        kclp_pkg::CFG_REPEAT:   regs_nxt.repeat_window_ticks = cfg_wdata;
        default:                regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.debounce_ticks      <= 16'd2;
      regs_r.long_press_ticks    <= 16'd100;
      regs_r.hold_period_ticks   <= 16'd20;
      regs_r.repeat_window_ticks <= 16'd30;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

// ===== hw/rtl/kclp_state.sv =====
// per-key state store: settled level, mode, tick counter, press count
// depends on kclp_pkg; read and written at the key of the transaction in work

module kclp_state (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [kclp_pkg::KEY_W-1:0]  key,
  input  logic                        wr_en,
  input  kclp_pkg::key_state_t        wr_state,
  output kclp_pkg::key_state_t        rd_state
);

  kclp_pkg::key_state_t state_r [kclp_pkg::NUM_KEYS];

  // read port for the key under work
  assign rd_state = state_r[key];

  // write back the updated entry, reset clears all keys
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < kclp_pkg::NUM_KEYS; i++) begin
        state_r[i].settled <= 1'b0;
        state_r[i].mode    <= kclp_pkg::MODE_IDLE;
        state_r[i].ticks   <= '0;
        state_r[i].presses <= '0;
      end
    end else if (wr_en) begin
      state_r[key] <= wr_state;
    end
  end

endmodule

// ===== hw/rtl/kclp_step.sv =====
// next-state and event logic for one scan tick of one key
// depends on kclp_pkg; purely combinational

module kclp_step (
  input  kclp_pkg::key_state_t cur,
  input  logic                 lvl,
  input  kclp_pkg::cfg_regs_t  regs,
  output kclp_pkg::key_state_t nxt,
  output kclp_pkg::step_res_t  res
);

  logic [kclp_pkg::TICK_W-1:0]  ticks_inc;
  logic [kclp_pkg::PRESS_W-1:0] presses_inc;

  // saturating counters
  assign ticks_inc   = (cur.ticks == kclp_pkg::TICK_MAX) ? cur.ticks
                                                          : cur.ticks + 1'b1;
  assign presses_inc = (cur.presses == kclp_pkg::PRESS_MAX) ? cur.presses
                                                             : cur.presses + 1'b1;

  always_comb begin
    nxt      = cur;
    res.fire = 1'b0;
    res.ev   = kclp_pkg::EV_DOWN;
    if (lvl != cur.settled) begin
      // debounce a level change
      if (ticks_inc >= regs.debounce_ticks) begin
        nxt.settled = lvl;
        nxt.ticks   = '0;
      end else begin
        nxt.ticks = ticks_inc;
      end
    end else begin
      // mode machine on a settled level
      case (cur.mode)
        kclp_pkg::MODE_IDLE: begin
          if (lvl) begin
            nxt.mode    = kclp_pkg::MODE_DOWN;
            nxt.ticks   = '0;
            nxt.presses = kclp_pkg::PRESS_W'(1);
            res.fire    = 1'b1;
            res.ev      = kclp_pkg::EV_DOWN;
          end
        end
        kclp_pkg::MODE_DOWN: begin
          if (!lvl) begin
            nxt.mode  = kclp_pkg::MODE_UP;
            nxt.ticks = '0;
            if (cur.presses == kclp_pkg::PRESS_W'(1)) begin
              res.fire = 1'b1;
              res.ev   = kclp_pkg::EV_UP;
            end
          end else if (ticks_inc >= regs.long_press_ticks) begin
            nxt.mode    = kclp_pkg::MODE_LONG;
            nxt.ticks   = '0;
            nxt.presses = '0;
            res.fire    = 1'b1;
            res.ev      = kclp_pkg::EV_LONG_START;
          end else begin
            nxt.ticks = ticks_inc;
          end
        end
        kclp_pkg::MODE_LONG: begin
          if (!lvl) begin
            nxt.mode    = kclp_pkg::MODE_IDLE;
            nxt.ticks   = '0;
            nxt.presses = '0;
            res.fire    = 1'b1;
            res.ev      = kclp_pkg::EV_LONG_RELEASE;
          end else if (ticks_inc >= regs.hold_period_ticks) begin
            nxt.ticks = '0;
            res.fire  = 1'b1;
            res.ev    = kclp_pkg::EV_LONG_HOLD;
          end else begin
            nxt.ticks = ticks_inc;
          end
        end
        kclp_pkg::MODE_UP: begin
          if (lvl) begin
            nxt.mode    = kclp_pkg::MODE_DOWN;
            nxt.ticks   = '0;
            nxt.presses = presses_inc;
          end else if (ticks_inc >= regs.repeat_window_ticks) begin
            // window closed: report a multi-press sequence
            if (cur.presses > kclp_pkg::PRESS_W'(1)) begin
              res.fire = 1'b1;
              res.ev   = kclp_pkg::EV_REPEAT;
            end
            nxt.mode    = kclp_pkg::MODE_IDLE;
            nxt.ticks   = '0;
            nxt.presses = '0;
          end else begin
            nxt.ticks = ticks_inc;
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/key_click_long_press_detector_top.sv =====
// top level of the key click / long press detector
// depends on kclp_pkg, kclp_cfg, kclp_state, kclp_step

// Takes one scan tick (key index and raw level) per clock cycle while the
// input side does not stall, and gives at most one key event per tick. A tick is
// captured in an input register; in the following cycle the per-key state (held
// in flip-flops, one entry per key) is read and updated by the debounce and mode
// logic, and when the tick retires the state is written back and any event is
// loaded into the result register that presents it. Because the state of a key is
// written back in the same cycle that it is read, ticks for the same key may
// follow each other in consecutive cycles. The input side only stalls when the
// result register is held by a stalled event and the tick in work would raise
// another one.
// Configuration is taken on any cycle with cfg_we high and should be written
// while no tick is in flight; ticks for keys beyond the key count are dropped.

module key_click_long_press_detector_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  kclp_pkg::in_item_t             in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output kclp_pkg::out_item_t            out_data,
  // configuration port
  input  logic                           cfg_we,
  input  logic [kclp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kclp_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam logic [kclp_pkg::KEY_W:0] KEY_LIMIT = (kclp_pkg::KEY_W+1)'(kclp_pkg::NUM_KEYS);

  kclp_pkg::cfg_regs_t  regs;
  kclp_pkg::key_state_t cur_state;
  kclp_pkg::key_state_t nxt_state;
  kclp_pkg::step_res_t  res;

  logic                proc_valid_r, proc_valid_nxt;
  kclp_pkg::in_item_t  proc_item_r;
  logic                out_valid_r, out_valid_nxt;
  kclp_pkg::out_item_t out_item_r;

  logic in_accept;
  logic key_ok;
  logic fire;
  logic adv;

  kclp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  kclp_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .key      (proc_item_r.key_index),
    .wr_en    (adv && key_ok),
    .wr_state (nxt_state),
    .rd_state (cur_state)
  );

  kclp_step u_step (
    .cur  (cur_state),
    .lvl  (proc_item_r.raw_level),
    .regs (regs),
    .nxt  (nxt_state),
    .res  (res)
  );

  // the tick in work retires unless its event would overwrite a stalled one
  assign key_ok    = ({1'b0, proc_item_r.key_index} < KEY_LIMIT);
  assign fire      = key_ok && res.fire;
  assign adv       = proc_valid_r && (!fire || !out_valid_r || !out_stall);
  assign in_stall  = proc_valid_r && !adv;
  assign in_accept = in_valid && !in_stall;

  assign proc_valid_nxt = in_accept || (proc_valid_r && !adv);
  assign out_valid_nxt  = (out_valid_r && out_stall) || (adv && fire);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      proc_valid_r <= proc_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      proc_item_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv && fire) begin
      out_item_r.key_number <= proc_item_r.key_index;
      out_item_r.event_code <= res.ev;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // a firing tick held back by a stalled result stays in the input register
  a_hold_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_valid_r && fire && out_valid_r && out_stall) |=> proc_valid_r)
    else $error("firing tick lost while result stalled");

  // a new result only comes from a retired firing tick
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> $past(adv && fire))
    else $error("result appeared without a firing tick");

  // a debounce tick never raises an event
  a_debounce_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_valid_r && (proc_item_r.raw_level != cur_state.settled)) |-> !res.fire)
    else $error("event raised during debounce");

endmodule
